### rtl/scd1_pkg.sv
// Shared types, key codes and character tables for the set 1 scan code decoder.
package scd1_pkg;

  typedef enum logic [1:0] {
    PFX_NONE = 2'b00,
    PFX_E0   = 2'b01,
    PFX_E1   = 2'b10
  } prefix_t;

  typedef struct packed {
    logic ctrl_r;
    logic ctrl_l;
    logic alt_r;
    logic alt_l;
    logic shift;
  } mods_t;

  typedef struct packed {
    logic scroll;
    logic num;
    logic caps;
  } locks_t;

  // Packed so that key_valid sits in bit 0 and scroll lock in bit 23
  typedef struct packed {
    locks_t      locks;
    mods_t       mods;
    logic [6:0]  key_scan;
    logic [7:0]  ascii_char;
    logic        key_valid;
  } result_t;

  localparam int unsigned RESULT_W = $bits(result_t);

  localparam logic [7:0] BYTE_E0 = 8'hE0;
  localparam logic [7:0] BYTE_E1 = 8'hE1;

  localparam logic [6:0] SC_LSHIFT    = 7'd42;
  localparam logic [6:0] SC_RSHIFT    = 7'd54;
  localparam logic [6:0] SC_ALT       = 7'd56;
  localparam logic [6:0] SC_CTRL      = 7'd29;
  localparam logic [6:0] SC_CAPS      = 7'd58;
  localparam logic [6:0] SC_SCROLL    = 7'd70;
  localparam logic [6:0] SC_NUM       = 7'd69;
  localparam logic [6:0] SC_PAD_FIRST = 7'd71;
  localparam logic [6:0] SC_PAD_LAST  = 7'd83;
  localparam logic [6:0] SC_DIV       = 7'd53;
  localparam logic [6:0] DIV_SCAN     = 7'd8;
  localparam logic [7:0] DIV_CHAR     = "/";

  function automatic logic is_letter(input logic [6:0] code);
    is_letter = (code >= 7'd16 && code <= 7'd26) || (code >= 7'd30 && code <= 7'd40) ||
                (code >= 7'd44 && code <= 7'd50);
  endfunction

  function automatic logic [7:0] plain_char(input logic [6:0] code);
    unique case (code)
      7'd2:  plain_char = "1";
      7'd3:  plain_char = "2";
      7'd4:  plain_char = "3";
      7'd5:  plain_char = "4";
      7'd6:  plain_char = "5";
      7'd7:  plain_char = "6";
      7'd8:  plain_char = "7";
      7'd9:  plain_char = "8";
      7'd10: plain_char = "9";
      7'd11: plain_char = "0";
      7'd12: plain_char = 8'd225;
      7'd13: plain_char = 8'd39;
      7'd14: plain_char = 8'd8;
      7'd16: plain_char = "q";
      7'd17: plain_char = "w";
      7'd18: plain_char = "e";
      7'd19: plain_char = "r";
      7'd20: plain_char = "t";
      7'd21: plain_char = "z";
      7'd22: plain_char = "u";
      7'd23: plain_char = "i";
      7'd24: plain_char = "o";
      7'd25: plain_char = "p";
      7'd26: plain_char = 8'd129;
      7'd27: plain_char = "+";
      7'd28: plain_char = 8'd10;
      7'd30: plain_char = "a";
      7'd31: plain_char = "s";
      7'd32: plain_char = "d";
      7'd33: plain_char = "f";
      7'd34: plain_char = "g";
      7'd35: plain_char = "h";
      7'd36: plain_char = "j";
      7'd37: plain_char = "k";
      7'd38: plain_char = "l";
      7'd39: plain_char = 8'd148;
      7'd40: plain_char = 8'd132;
      7'd41: plain_char = "^";
      7'd43: plain_char = "#";
      7'd44: plain_char = "y";
      7'd45: plain_char = "x";
      7'd46: plain_char = "c";
      7'd47: plain_char = "v";
      7'd48: plain_char = "b";
      7'd49: plain_char = "n";
      7'd50: plain_char = "m";
      7'd51: plain_char = ",";
      7'd52: plain_char = ".";
      7'd53: plain_char = "-";
      7'd55: plain_char = "*";
      7'd57: plain_char = " ";
      7'd74: plain_char = "-";
      7'd78: plain_char = "+";
      7'd86: plain_char = "<";
      default: plain_char = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] upper_char(input logic [6:0] code);
    unique case (code)
      7'd2:  upper_char = "!";
      7'd3:  upper_char = "\"";
      7'd4:  upper_char = 8'd21;
      7'd5:  upper_char = "$";
      7'd6:  upper_char = "%";
      7'd7:  upper_char = "&";
      7'd8:  upper_char = "/";
      7'd9:  upper_char = "(";
      7'd10: upper_char = ")";
      7'd11: upper_char = "=";
      7'd12: upper_char = "?";
      7'd13: upper_char = 8'd96;
      7'd16: upper_char = "Q";
      7'd17: upper_char = "W";
      7'd18: upper_char = "E";
      7'd19: upper_char = "R";
      7'd20: upper_char = "T";
      7'd21: upper_char = "Z";
      7'd22: upper_char = "U";
      7'd23: upper_char = "I";
      7'd24: upper_char = "O";
      7'd25: upper_char = "P";
      7'd26: upper_char = 8'd154;
      7'd27: upper_char = "*";
      7'd30: upper_char = "A";
      7'd31: upper_char = "S";
      7'd32: upper_char = "D";
      7'd33: upper_char = "F";
      7'd34: upper_char = "G";
      7'd35: upper_char = "H";
      7'd36: upper_char = "J";
      7'd37: upper_char = "K";
      7'd38: upper_char = "L";
      7'd39: upper_char = 8'd153;
      7'd40: upper_char = 8'd142;
      7'd41: upper_char = 8'd248;
      7'd43: upper_char = 8'd39;
      7'd44: upper_char = "Y";
      7'd45: upper_char = "X";
      7'd46: upper_char = "C";
      7'd47: upper_char = "V";
      7'd48: upper_char = "B";
      7'd49: upper_char = "N";
      7'd50: upper_char = "M";
      7'd51: upper_char = ";";
      7'd52: upper_char = ":";
      7'd53: upper_char = "_";
      7'd57: upper_char = " ";
      7'd86: upper_char = ">";
      default: upper_char = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] altgr_char(input logic [6:0] code);
    unique case (code)
      7'd3:  altgr_char = 8'd253;
      7'd8:  altgr_char = "{";
      7'd9:  altgr_char = "[";
      7'd10: altgr_char = "]";
      7'd11: altgr_char = "}";
      7'd12: altgr_char = "\\";
      7'd16: altgr_char = "@";
      7'd27: altgr_char = "~";
      7'd50: altgr_char = 8'd230;
      7'd86: altgr_char = "|";
      default: altgr_char = 8'd0;
    endcase
  endfunction

  // Keypad with num lock, indexed from the home key
  function automatic logic [7:0] pad_char(input logic [3:0] idx);
    unique case (idx)
      4'd0:  pad_char = "7";
      4'd1:  pad_char = "8";
      4'd2:  pad_char = "9";
      4'd3:  pad_char = "-";
      4'd4:  pad_char = "4";
      4'd5:  pad_char = "5";
      4'd6:  pad_char = "6";
      4'd7:  pad_char = "+";
      4'd8:  pad_char = "1";
      4'd9:  pad_char = "2";
      4'd10: pad_char = "3";
      4'd11: pad_char = "0";
      4'd12: pad_char = ",";
      default: pad_char = 8'd0;
    endcase
  endfunction

  function automatic logic [6:0] pad_scan(input logic [3:0] idx);
    unique case (idx)
      4'd0:  pad_scan = 7'd8;
      4'd1:  pad_scan = 7'd9;
      4'd2:  pad_scan = 7'd10;
      4'd3:  pad_scan = 7'd53;
      4'd4:  pad_scan = 7'd5;
      4'd5:  pad_scan = 7'd6;
      4'd6:  pad_scan = 7'd7;
      4'd7:  pad_scan = 7'd27;
      4'd8:  pad_scan = 7'd2;
      4'd9:  pad_scan = 7'd3;
      4'd10: pad_scan = 7'd4;
      4'd11: pad_scan = 7'd11;
      4'd12: pad_scan = 7'd51;
      default: pad_scan = 7'd0;
    endcase
  endfunction

endpackage

### rtl/scd1_core.sv
// Prefix, modifier and lock state with the per-byte decode logic.
module scd1_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          scan_byte,
  output scd1_pkg::result_t   result
);
  import scd1_pkg::*;

  prefix_t     prefix, prefix_next;
  mods_t       mods, mods_next;
  locks_t      locks, locks_next;

  logic [6:0]  code;
  logic [3:0]  pad_idx;
  logic        e0;
  logic        done;
  logic [7:0]  asc;
  logic [6:0]  scan;
  logic        valid;

  assign code    = scan_byte[6:0];
  assign e0      = (prefix == PFX_E0);
  assign pad_idx = 4'(code - SC_PAD_FIRST);

  always_comb begin
    prefix_next = prefix;
    mods_next   = mods;
    locks_next  = locks;
    done        = 1'b0;
    asc         = 8'd0;
    scan        = 7'd0;
    if (scan_byte == BYTE_E0) begin
      prefix_next = PFX_E0;
    end else if (scan_byte == BYTE_E1) begin
      prefix_next = PFX_E1;
    end else if (scan_byte[7]) begin
      prefix_next = PFX_NONE;
      if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        mods_next.shift = 1'b0;
      end else if (code == SC_ALT) begin
        if (e0) mods_next.alt_r = 1'b0;
        else    mods_next.alt_l = 1'b0;
      end else if (code == SC_CTRL) begin
        if (e0) mods_next.ctrl_r = 1'b0;
        else    mods_next.ctrl_l = 1'b0;
      end
    end else begin
      prefix_next = PFX_NONE;
      if (code == SC_LSHIFT || code == SC_RSHIFT) begin
        mods_next.shift = 1'b1;
      end else if (code == SC_ALT) begin
        if (e0) mods_next.alt_r = 1'b1;
        else    mods_next.alt_l = 1'b1;
      end else if (code == SC_CTRL) begin
        if (e0) mods_next.ctrl_r = 1'b1;
        else    mods_next.ctrl_l = 1'b1;
      end else if (code == SC_CAPS) begin
        locks_next.caps = ~locks.caps;
      end else if (code == SC_SCROLL) begin
        locks_next.scroll = ~locks.scroll;
      end else if (code == SC_NUM && !mods.ctrl_l) begin
        locks_next.num = ~locks.num;
      end else begin
        // ordinary key (num with left ctrl held is Pause and lands here too)
        done = 1'b1;
        scan = code;
        if (code == SC_DIV && e0) begin
          asc  = DIV_CHAR;
          scan = DIV_SCAN;
        end else if (locks.num && prefix == PFX_NONE &&
                     code >= SC_PAD_FIRST && code <= SC_PAD_LAST) begin
          asc  = pad_char(pad_idx);
          scan = pad_scan(pad_idx);
        end else if (mods.alt_r) begin
          asc = altgr_char(code);
        end else if (mods.shift) begin
          asc = upper_char(code);
        end else if (locks.caps && is_letter(code)) begin
          asc = upper_char(code);
        end else begin
          asc = plain_char(code);
        end
      end
    end
  end

  assign valid = done && (scan != 7'd0);

  always_comb begin
    result.key_valid  = valid;
    result.ascii_char = valid ? asc : 8'd0;
    result.key_scan   = valid ? scan : 7'd0;
    result.mods       = mods_next;
    result.locks      = locks_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix <= PFX_NONE;
      mods   <= '0;
      locks  <= '0;
    end else if (step) begin
      prefix <= prefix_next;
      mods   <= mods_next;
      locks  <= locks_next;
    end
  end

endmodule

### rtl/scan_code_set1_to_ascii_decoder_unit.sv
// Top level: input register, decode core and result register for set 1 scan codes.
// Takes one keyboard byte (scan code set 1) per item and returns one result per item:
// a key flag, the German-layout character and remapped scan code, and the modifier and
// lock flags as they stand after that byte (the lock flags can drive the keyboard LEDs).
// E0/E1 prefixes, break codes and modifier or lock keys give a result with key_valid low.
// One item is taken per clock while the output does not stall. A taken byte sits in the
// input register, is decoded and moves to the result register, from which its result is
// offered until it leaves. The decode state is updated as the item passes from one
// register to the other. Output back-pressure stalls both registers together, and the
// input side stays ready while the input register is empty.
module scan_code_set1_to_ascii_decoder_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,   // [7:0] scan_byte
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] key_valid, [8:1] ascii_char, [15:9] key_scan, [16] shift_down,
  // [17] alt_left_down, [18] alt_right_down, [19] ctrl_left_down,
  // [20] ctrl_right_down, [21] caps_on, [22] num_on, [23] scroll_on
  output logic [scd1_pkg::RESULT_W-1:0]   m_axis_tdata
);
  import scd1_pkg::*;

  logic        in_valid;
  logic [7:0]  in_byte;
  logic        out_valid;
  result_t     out_data;
  result_t     core_result;
  logic        advance;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  scd1_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .scan_byte (in_byte),
    .result    (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= core_result;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  // a completed key always carries a nonzero scan code
  a_key_scan_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.key_valid |-> out_data.key_scan != 7'd0)
    else $error("key result with zero scan code");

  a_nokey_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.key_valid |-> out_data.ascii_char == 8'd0 &&
                                         out_data.key_scan == 7'd0)
    else $error("character or scan code on a non-key result");

  // a waiting item is neither lost nor altered while the result side stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("input item dropped during stall");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !advance |=> $stable(out_data))
    else $error("result changed without an item advancing");

endmodule

### test/tb_scan_code_set1_to_ascii_decoder_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for the set 1 scan code decoder: directed and random key bytes.
module tb_scan_code_set1_to_ascii_decoder_unit;
  import scd1_pkg::*;

  localparam int N_ITEMS   = 1150;
  localparam int CALM_TAIL = 150;
  localparam int LONG_HOLD = 300;
  localparam int TAB_LEN   = 89;
  localparam int PAD_KEYS  = 13;

  // Tracks decoder state and predicts one result per accepted scan byte
  class key_decode_scoreboard;
    prefix_t    prefix_st;
    mods_t      mods_st;
    locks_t     locks_st;
    logic [7:0] plain_map [TAB_LEN];
    logic [7:0] upper_map [TAB_LEN];
    logic [7:0] altgr_map [TAB_LEN];
    logic [7:0] pad_chars [PAD_KEYS];
    logic [6:0] pad_codes [PAD_KEYS];
    result_t    expected_q [$];
    int         n_bytes;
    int         n_results;
    int         n_keys;
    int         n_errors;

    function new();
      prefix_st = PFX_NONE;
      mods_st   = '0;
      locks_st  = '0;
      n_bytes   = 0;
      n_results = 0;
      n_keys    = 0;
      n_errors  = 0;
      plain_map = '{
        8'd0, 8'd0, "1", "2", "3", "4", "5", "6", "7", "8",
        "9", "0", 8'd225, 8'd39, 8'd8, 8'd0, "q", "w", "e", "r",
        "t", "z", "u", "i", "o", "p", 8'd129, "+", 8'd10, 8'd0,
        "a", "s", "d", "f", "g", "h", "j", "k", "l", 8'd148,
        8'd132, "^", 8'd0, "#", "y", "x", "c", "v", "b", "n",
        "m", ",", ".", "-", 8'd0, "*", 8'd0, " ", 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, "-", 8'd0, 8'd0, 8'd0, "+", 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, "<", 8'd0, 8'd0};
      upper_map = '{
        8'd0, 8'd0, "!", "\"", 8'd21, "$", "%", "&", "/", "(",
        ")", "=", "?", 8'd96, 8'd0, 8'd0, "Q", "W", "E", "R",
        "T", "Z", "U", "I", "O", "P", 8'd154, "*", 8'd0, 8'd0,
        "A", "S", "D", "F", "G", "H", "J", "K", "L", 8'd153,
        8'd142, 8'd248, 8'd0, 8'd39, "Y", "X", "C", "V", "B", "N",
        "M", ";", ":", "_", 8'd0, 8'd0, 8'd0, " ", 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
        8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, ">", 8'd0, 8'd0};
      foreach (altgr_map[i]) altgr_map[i] = 8'd0;
      altgr_map[3]  = 8'd253;
      altgr_map[8]  = "{";
      altgr_map[9]  = "[";
      altgr_map[10] = "]";
      altgr_map[11] = "}";
      altgr_map[12] = "\\";
      altgr_map[16] = "@";
      altgr_map[27] = "~";
      altgr_map[50] = 8'd230;
      altgr_map[86] = "|";
      pad_chars = '{"7", "8", "9", "-", "4", "5", "6", "+", "1", "2", "3", "0", ","};
      pad_codes = '{7'd8, 7'd9, 7'd10, 7'd53, 7'd5, 7'd6, 7'd7, 7'd27, 7'd2, 7'd3,
                    7'd4, 7'd11, 7'd51};
    endfunction

    function logic letter_key(logic [6:0] c);
      return (c >= 7'd16 && c <= 7'd26) || (c >= 7'd30 && c <= 7'd40) ||
             (c >= 7'd44 && c <= 7'd50);
    endfunction

    function result_t decode_byte(logic [7:0] b);
      logic [6:0] c;
      logic       e0;
      logic       done;
      result_t    r;
      c    = b[6:0];
      e0   = (prefix_st == PFX_E0);
      done = 1'b0;
      r    = '0;
      if (b == BYTE_E0 || b == BYTE_E1) begin
        prefix_st = (b == BYTE_E0) ? PFX_E0 : PFX_E1;
      end else if (b[7]) begin
        if (c == SC_LSHIFT || c == SC_RSHIFT) mods_st.shift = 1'b0;
        else if (c == SC_ALT) begin
          if (e0) mods_st.alt_r = 1'b0;
          else mods_st.alt_l = 1'b0;
        end else if (c == SC_CTRL) begin
          if (e0) mods_st.ctrl_r = 1'b0;
          else mods_st.ctrl_l = 1'b0;
        end
        prefix_st = PFX_NONE;
      end else begin
        if (c == SC_LSHIFT || c == SC_RSHIFT) mods_st.shift = 1'b1;
        else if (c == SC_ALT) begin
          if (e0) mods_st.alt_r = 1'b1;
          else mods_st.alt_l = 1'b1;
        end else if (c == SC_CTRL) begin
          if (e0) mods_st.ctrl_r = 1'b1;
          else mods_st.ctrl_l = 1'b1;
        end else if (c == SC_CAPS) locks_st.caps = ~locks_st.caps;
        else if (c == SC_SCROLL) locks_st.scroll = ~locks_st.scroll;
        else if (c == SC_NUM && !mods_st.ctrl_l) locks_st.num = ~locks_st.num;
        else begin
          // ctrl-left + num lock (pause) falls through to here as an ordinary key
          done       = 1'b1;
          r.key_scan = c;
          if (c == SC_DIV && prefix_st == PFX_E0) begin
            r.ascii_char = DIV_CHAR;
            r.key_scan   = DIV_SCAN;
          end else if (locks_st.num && prefix_st == PFX_NONE &&
                       c >= SC_PAD_FIRST && c <= SC_PAD_LAST) begin
            r.ascii_char = pad_chars[c - SC_PAD_FIRST];
            r.key_scan   = pad_codes[c - SC_PAD_FIRST];
          end else if (mods_st.alt_r) begin
            r.ascii_char = (c < TAB_LEN) ? altgr_map[c] : 8'd0;
          end else if (mods_st.shift || (locks_st.caps && letter_key(c))) begin
            r.ascii_char = (c < TAB_LEN) ? upper_map[c] : 8'd0;
          end else begin
            r.ascii_char = (c < TAB_LEN) ? plain_map[c] : 8'd0;
          end
        end
        prefix_st = PFX_NONE;
      end
      if (!done || r.key_scan == 7'd0) begin
        done         = 1'b0;
        r.ascii_char = 8'd0;
        r.key_scan   = 7'd0;
      end
      r.key_valid = done;
      r.mods      = mods_st;
      r.locks     = locks_st;
      return r;
    endfunction

    function void note_byte(logic [7:0] b);
      n_bytes++;
      expected_q.push_back(decode_byte(b));
    endfunction

    function void check_result(result_t got);
      result_t exp;
      string   bad;
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10) $display("ERROR: result %h arrived with nothing outstanding", got);
        return;
      end
      exp = expected_q.pop_front();
      bad = "";
      if (got.key_valid   !== exp.key_valid)   bad = {bad, " key_valid"};
      if (got.ascii_char  !== exp.ascii_char)  bad = {bad, " ascii_char"};
      if (got.key_scan    !== exp.key_scan)    bad = {bad, " key_scan"};
      if (got.mods.shift  !== exp.mods.shift)  bad = {bad, " shift_down"};
      if (got.mods.alt_l  !== exp.mods.alt_l)  bad = {bad, " alt_left_down"};
      if (got.mods.alt_r  !== exp.mods.alt_r)  bad = {bad, " alt_right_down"};
      if (got.mods.ctrl_l !== exp.mods.ctrl_l) bad = {bad, " ctrl_left_down"};
      if (got.mods.ctrl_r !== exp.mods.ctrl_r) bad = {bad, " ctrl_right_down"};
      if (got.locks.caps  !== exp.locks.caps)  bad = {bad, " caps_on"};
      if (got.locks.num   !== exp.locks.num)   bad = {bad, " num_on"};
      if (got.locks.scroll !== exp.locks.scroll) bad = {bad, " scroll_on"};
      if (got.key_valid === 1'b1) n_keys++;
      if (bad != "") begin
        n_errors++;
        if (n_errors <= 10)
          $display({"ERROR: result %0d differs in%s: expected %h (char %h scan %h), ",
                    "got %h (char %h scan %h)"},
                   n_results, bad, exp, exp.ascii_char, exp.key_scan,
                   got, got.ascii_char, got.key_scan);
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [RESULT_W-1:0] m_axis_tdata;

  key_decode_scoreboard sb;
  int n_sent    = 0;
  int gap_pct   = 0;
  int stall_pct = 15;
  bit calm      = 1'b0;
  bit hold_req  = 1'b0;

  scan_code_set1_to_ascii_decoder_unit i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] make_code(logic [6:0] c);
    return {1'b0, c};
  endfunction

  function automatic logic [7:0] break_code(logic [6:0] c);
    return {1'b1, c};
  endfunction

  // Offer one byte, hold it until taken, then maybe leave a gap
  task automatic put(input logic [7:0] b);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    n_sent++;
    calm = (n_sent >= N_ITEMS - CALM_TAIL);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && s_axis_tvalid && s_axis_tready) sb.note_byte(s_axis_tdata);
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // Result side: random stalls, one long hold-off so the input side backs up
  initial begin
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 45;
        endcase
      end
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("ERROR: run timed out with %0d results outstanding", sb.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int         kind;
    int         next_mode;
    logic [6:0] code;
    logic       brk;
    sb = new();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: zero code, caps on letters, both shifts, AltGr, pause, keypad, divide
    put(8'h00);
    put(8'h10);
    put(make_code(SC_CAPS));
    put(8'h10);
    put(make_code(SC_LSHIFT));
    put(8'h02);
    put(break_code(SC_RSHIFT));
    put(BYTE_E0);
    put(make_code(SC_ALT));
    put(8'h10);
    put(BYTE_E0);
    put(break_code(SC_ALT));
    put(make_code(SC_CTRL));
    put(make_code(SC_NUM));
    put(break_code(SC_CTRL));
    put(make_code(SC_NUM));
    put(make_code(SC_PAD_FIRST));
    put(BYTE_E0);
    put(make_code(SC_PAD_LAST));
    put(BYTE_E0);
    put(make_code(SC_DIV));
    put(8'h7F);
    put(make_code(SC_SCROLL));
    put(8'hFF);
    // E1 picks the left-hand ctrl, so this break leaves right ctrl held
    put(BYTE_E0);
    put(make_code(SC_CTRL));
    put(BYTE_E1);
    put(break_code(SC_CTRL));

    hold_req  = 1'b1;
    gap_pct   = 0;
    next_mode = n_sent + 64;
    while (n_sent < N_ITEMS) begin
      if (n_sent >= next_mode) begin
        next_mode = n_sent + 64;
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 45;
        endcase
      end
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        if ($urandom_range(0, 3) == 0) code = 7'($urandom_range(0, 127));
        else code = 7'($urandom_range(2, TAB_LEN - 1));
        put(make_code(code));
        if ($urandom_range(0, 1)) put(break_code(code));
      end else if (kind < 45) begin
        if ($urandom_range(0, 6) == 0) begin
          put(BYTE_E0);
          put(make_code(SC_DIV));
        end else begin
          if ($urandom_range(0, 4) == 0) put(BYTE_E0);
          code = 7'($urandom_range(int'(SC_PAD_LAST), int'(SC_PAD_FIRST)));
          put(make_code(code));
        end
      end else if (kind < 60) begin
        case ($urandom_range(0, 3))
          0:       code = SC_LSHIFT;
          1:       code = SC_RSHIFT;
          2:       code = SC_ALT;
          default: code = SC_CTRL;
        endcase
        brk = ($urandom_range(0, 9) < 4);
        if ($urandom_range(0, 1)) put(BYTE_E0);
        put({brk, code});
      end else if (kind < 68) begin
        case ($urandom_range(0, 2))
          0:       code = SC_CAPS;
          1:       code = SC_SCROLL;
          default: code = SC_NUM;
        endcase
        put(make_code(code));
      end else if (kind < 78) begin
        put(BYTE_E0);
        put(8'($urandom_range(0, 255)));
      end else if (kind < 83) begin
        put(BYTE_E1);
        put(8'($urandom_range(0, 255)));
      end else if (kind < 90) begin
        code = 7'($urandom_range(0, 127));
        put(break_code(code));
      end else begin
        put(8'($urandom_range(0, 255)));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d scan bytes: prefixes, make/break of modifiers, lock toggles,",
             sb.n_bytes);
    $display("keypad, divide, pause and random codes; %0d results checked, %0d completed keys",
             sb.n_results, sb.n_keys);
    if (sb.n_errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("ERROR: %0d mismatches, %0d results missing", sb.n_errors, sb.expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
rtl/scd1_pkg.sv
rtl/scd1_core.sv
rtl/scan_code_set1_to_ascii_decoder_unit.sv
test/tb_scan_code_set1_to_ascii_decoder_unit.sv
